FILE: sv/klsm_pkg.sv
package klsm_pkg;

	localparam int NUM_CHANNELS = 13;
	localparam int CH_CNT_W = $clog2(NUM_CHANNELS + 1);
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MAP_W = 4 * NUM_CHANNELS;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
	localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

	localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [6:0] NOTE_MAX = 7'd127;

	localparam logic [MAP_W-1:0] NOTE_MAP_RST = MAP_W'(64'd974547855360018);
	localparam logic [6:0] BASE_NOTE_RST = 7'd60;
	localparam logic [6:0] ON_VELOCITY_RST = 7'd100;
	localparam logic [7:0] LOCKOUT_MS_RST = 8'd10;

	typedef enum logic [1:0] {
		REG_NOTE_MAP    = 2'd0,
		REG_BASE_NOTE   = 2'd1,
		REG_ON_VELOCITY = 2'd2,
		REG_LOCKOUT_MS  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_WALK,
		FE_FLUSH
	} fe_state_t;

	typedef struct packed {
		logic [CH_IDX_W-1:0] chan;
		logic                level;
		logic                last;
	} note_evt_t;

	typedef struct packed {
		logic [MAP_W-1:0] note_map;
		logic [6:0]       base_note;
		logic [6:0]       on_velocity;
	} back_cfg_t;

endpackage

FILE: sv/klsm_front.sv
module klsm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        now_ms,
	input  logic [klsm_pkg::NUM_CHANNELS-1:0]  pin_levels,
	input  logic [7:0]                         lockout_ms,
	output logic                               evq_push,
	output klsm_pkg::note_evt_t                evq_data,
	input  logic                               evq_full
);
	import klsm_pkg::*;

	fe_state_t             state_q, state_d;
	logic [CH_CNT_W-1:0]   chan_q;
	logic [31:0]           now_q;
	logic [NUM_CHANNELS-1:0] levels_q;
	logic [NUM_CHANNELS-1:0] acc_q;
	logic [31:0]           stamp_q [NUM_CHANNELS];
	logic                  pend_v_q;
	note_evt_t             pend_q;

	logic                  walking, flushing, take;
	logic [CH_IDX_W-1:0]   idx;
	logic [31:0]           elapsed;
	logic                  new_b, old_b, elig, push, step, last_chan;

	assign idx = chan_q[CH_IDX_W-1:0];
	assign elapsed = now_q - stamp_q[idx];
	assign new_b = levels_q[idx];
	assign old_b = acc_q[idx];
	assign elig = walking && (new_b != old_b) && (elapsed >= {24'd0, lockout_ms});
	assign push = pend_v_q && (elig || flushing);
	assign step = (walking || flushing) && !(push && evq_full);
	assign last_chan = (chan_q == CH_CNT_W'(NUM_CHANNELS - 1));
	assign take = in_valid && !in_stall;

	assign evq_push = push && !evq_full;
	always_comb begin
		evq_data = pend_q;
		evq_data.last = flushing;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (in_valid) state_d = FE_WALK;
			end
			FE_WALK: begin
				if (step && last_chan) state_d = FE_FLUSH;
			end
			FE_FLUSH: begin
				if (step) state_d = FE_IDLE;
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		walking = 1'b0;
		flushing = 1'b0;
		unique case (state_q)
			FE_IDLE:  in_stall = 1'b0;
			FE_WALK:  walking = 1'b1;
			FE_FLUSH: flushing = 1'b1;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			chan_q <= '0;
			pend_v_q <= 1'b0;
			acc_q <= '1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				stamp_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (take) begin
				chan_q <= '0;
			end else if (walking && step) begin
				chan_q <= chan_q + 1'b1;
				if (elig) begin
					acc_q[idx] <= new_b;
					stamp_q[idx] <= now_q;
					pend_v_q <= 1'b1;
				end
			end else if (flushing && step) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_q <= now_ms;
			levels_q <= pin_levels;
		end
		if (walking && step && elig) begin
			pend_q <= '{chan: idx, level: new_b, last: 1'b0};
		end
	end

`ifndef SYNTH
	a_take_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == FE_WALK && chan_q == '0))
		else $error("scan not started at first channel");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FE_WALK |-> chan_q < CH_CNT_W'(NUM_CHANNELS))
		else $error("channel counter past last channel");
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FE_FLUSH && !pend_v_q) |=> state_q == FE_IDLE)
		else $error("flush did not return to idle");
	a_no_lost_event: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FE_FLUSH && pend_v_q && !evq_full) |=> !pend_v_q)
		else $error("pending event not cleared after flush");
`endif

endmodule

FILE: sv/klsm_evq.sv
module klsm_evq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  klsm_pkg::note_evt_t  push_data,
	output logic                 full,
	input  logic                 pop,
	output klsm_pkg::note_evt_t  pop_data,
	output logic                 empty
);
	import klsm_pkg::*;

	note_evt_t             mem_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0]  wr_q, rd_q;
	logic [EVQ_CNT_W-1:0]  cnt_q;
	logic                  do_push, do_pop;

	assign full = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EVQ_CNT_W'(EVQ_DEPTH))
		else $error("event queue overfilled");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		EVQ_PTR_W'(wr_q - rd_q) == cnt_q[EVQ_PTR_W-1:0])
		else $error("queue pointers disagree with count");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> $stable(cnt_q))
		else $error("count moved while full and not popped");
`endif

endmodule

FILE: sv/klsm_back.sv
module klsm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  klsm_pkg::back_cfg_t  cfg,
	input  logic                 evq_empty,
	input  klsm_pkg::note_evt_t  evq_data,
	output logic                 evq_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           status_byte,
	output logic [6:0]           note_number,
	output logic [6:0]           velocity,
	output logic                 led_level,
	output logic                 last_of_scan
);
	import klsm_pkg::*;

	logic        out_valid_q;
	logic [7:0]  status_q;
	logic [6:0]  note_q, vel_q;
	logic        led_q, last_q;

	logic        load;
	logic [3:0]  offset;
	logic [7:0]  sum;
	logic [6:0]  note;

	assign load = !evq_empty && (!out_valid_q || !out_stall);
	assign evq_pop = load;
	assign offset = cfg.note_map[{evq_data.chan, 2'b00} +: 4];
	assign sum = {1'b0, cfg.base_note} + {4'd0, offset};
	assign note = sum[7] ? NOTE_MAX : sum[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= evq_data.level ? STATUS_NOTE_OFF : STATUS_NOTE_ON;
			vel_q <= evq_data.level ? 7'd0 : cfg.on_velocity;
			note_q <= note;
			led_q <= evq_data.level;
			last_q <= evq_data.last;
		end
	end

	assign out_valid = out_valid_q;
	assign status_byte = status_q;
	assign note_number = note_q;
	assign velocity = vel_q;
	assign led_level = led_q;
	assign last_of_scan = last_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !evq_pop)
		else $error("held word overwritten");
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		evq_pop |=> out_valid_q)
		else $error("popped event not presented");
	a_vel_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && led_q) |-> (vel_q == 7'd0 && status_q == STATUS_NOTE_OFF))
		else $error("release word carries note-on fields");
`endif

endmodule

FILE: sv/key_lockout_scan_to_midi_notes_core.sv
// Key scan to MIDI note encoder.
// Input channel: in_valid/in_stall carry one scan word (now_ms, pin_levels,
// active-low keys). A scan is taken when in_valid is high and in_stall low.
// Each scan is walked one channel per cycle while the event queue has room;
// a channel whose level changed and whose last accepted change is at least
// lockout_ms old yields one note word. Output channel: out_valid/out_stall
// carry note words in channel order; last_of_scan marks the final word of a
// scan. A scan with no change gives none. The front walker takes no new scan
// until it has walked every channel and flushed the pending event, holding
// in_stall high meanwhile. A stalled receiver holds the output register;
// words queue in a four-entry event queue, and once it is full the walker,
// and so in_stall, waits.
// Configuration: APB writes at byte address 8*i (note_map, base_note,
// on_velocity, lockout_ms); write only while idle.
// Reset: all keys released, change stamps zero, registers to their defaults,
// no words in flight.
module key_lockout_scan_to_midi_notes_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [4:0]                         paddr,
	input  logic [63:0]                        pwdata,
	output logic [63:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        now_ms,
	input  logic [klsm_pkg::NUM_CHANNELS-1:0]  pin_levels,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         status_byte,
	output logic [6:0]                         note_number,
	output logic [6:0]                         velocity,
	output logic                               led_level,
	output logic                               last_of_scan
);
	import klsm_pkg::*;

	logic [MAP_W-1:0] note_map_q;
	logic [6:0]       base_note_q;
	logic [6:0]       on_velocity_q;
	logic [7:0]       lockout_ms_q;

	reg_idx_t         reg_idx;
	logic             wr_en;
	back_cfg_t        back_cfg;

	logic             evq_push, evq_full, evq_pop, evq_empty;
	note_evt_t        evq_in, evq_out;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_map_q <= NOTE_MAP_RST;
			base_note_q <= BASE_NOTE_RST;
			on_velocity_q <= ON_VELOCITY_RST;
			lockout_ms_q <= LOCKOUT_MS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NOTE_MAP:    note_map_q <= pwdata[MAP_W-1:0];
				REG_BASE_NOTE:   base_note_q <= pwdata[6:0];
				REG_ON_VELOCITY: on_velocity_q <= pwdata[6:0];
				REG_LOCKOUT_MS:  lockout_ms_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_NOTE_MAP:    prdata = 64'(note_map_q);
			REG_BASE_NOTE:   prdata = {57'd0, base_note_q};
			REG_ON_VELOCITY: prdata = {57'd0, on_velocity_q};
			REG_LOCKOUT_MS:  prdata = {56'd0, lockout_ms_q};
			default:         prdata = '0;
		endcase
	end

	assign back_cfg = '{note_map: note_map_q, base_note: base_note_q,
		on_velocity: on_velocity_q};

	klsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.pin_levels (pin_levels),
		.lockout_ms (lockout_ms_q),
		.evq_push   (evq_push),
		.evq_data   (evq_in),
		.evq_full   (evq_full)
	);

	klsm_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (evq_push),
		.push_data (evq_in),
		.full      (evq_full),
		.pop       (evq_pop),
		.pop_data  (evq_out),
		.empty     (evq_empty)
	);

	klsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (back_cfg),
		.evq_empty    (evq_empty),
		.evq_data     (evq_out),
		.evq_pop      (evq_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status_byte  (status_byte),
		.note_number  (note_number),
		.velocity     (velocity),
		.led_level    (led_level),
		.last_of_scan (last_of_scan)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import klsm_pkg::*;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] note;
		logic [6:0] vel;
		logic       led;
		logic       last;
	} note_word_t;

	typedef struct packed {
		logic [31:0]             stamp;
		logic [NUM_CHANNELS-1:0] levels;
	} scan_word_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_RUNS
	} rx_mode_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [4:0]              paddr = '0;
	logic [63:0]             pwdata = '0;
	logic [63:0]             prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [31:0]             now_ms = '0;
	logic [NUM_CHANNELS-1:0] pin_levels = '1;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              status_byte;
	logic [6:0]              note_number;
	logic [6:0]              velocity;
	logic                    led_level;
	logic                    last_of_scan;

	logic [MAP_W-1:0]        cur_note_map = NOTE_MAP_RST;
	logic [6:0]              cur_base_note = BASE_NOTE_RST;
	logic [6:0]              cur_on_velocity = ON_VELOCITY_RST;
	logic [7:0]              cur_lockout = LOCKOUT_MS_RST;

	logic [NUM_CHANNELS-1:0] held_levels = '1;
	logic [31:0]             change_stamp [NUM_CHANNELS];

	note_word_t              expected_notes [$];
	scan_word_t              pending_scans [$];
	scan_word_t              next_scan;
	note_word_t              oldest_note;

	int                      errors = 0;
	int                      scans_sent = 0;
	int                      notes_checked = 0;
	int                      settings_used = 1;
	int                      burst_left = 0;
	int                      gap_left = 0;
	bit                      drain_pause = 1'b0;
	logic [31:0]             ms_clock = '0;
	logic [NUM_CHANNELS-1:0] key_shape = '1;

	rx_mode_t                rx_mode = RX_FREE;
	int                      mode_left = 0;
	int                      run_left = 0;
	logic                    run_level = 1'b0;

	key_lockout_scan_to_midi_notes_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status_byte  (status_byte),
		.note_number  (note_number),
		.velocity     (velocity),
		.led_level    (led_level),
		.last_of_scan (last_of_scan)
	);

	initial begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++) change_stamp[ch] = '0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_scan_notes(input logic [31:0] stamp,
			input logic [NUM_CHANNELS-1:0] levels);
		note_word_t prev;
		note_word_t cur;
		bit         have_prev;
		logic [31:0] age;
		logic [7:0]  sum;
		have_prev = 1'b0;
		prev = '0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			age = stamp - change_stamp[ch];
			if (age >= {24'd0, cur_lockout} && levels[ch] != held_levels[ch]) begin
				sum = {1'b0, cur_base_note} + {4'd0, cur_note_map[4*ch +: 4]};
				cur.status = levels[ch] ? STATUS_NOTE_OFF : STATUS_NOTE_ON;
				cur.note = (sum > 8'd127) ? NOTE_MAX : sum[6:0];
				cur.vel = levels[ch] ? 7'd0 : cur_on_velocity;
				cur.led = levels[ch];
				cur.last = 1'b0;
				held_levels[ch] = levels[ch];
				change_stamp[ch] = stamp;
				if (have_prev) expected_notes.push_back(prev);
				prev = cur;
				have_prev = 1'b1;
			end
		end
		if (have_prev) begin
			prev.last = 1'b1;
			expected_notes.push_back(prev);
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_NOTE_MAP:    cur_note_map = value[MAP_W-1:0];
			REG_BASE_NOTE:   cur_base_note = value[6:0];
			REG_ON_VELOCITY: cur_on_velocity = value[6:0];
			REG_LOCKOUT_MS:  cur_lockout = value[7:0];
			default: ;
		endcase
	endtask

	task automatic program_settings(input logic [63:0] map, input logic [6:0] base,
			input logic [6:0] vel, input logic [7:0] lockout);
		apb_write(REG_NOTE_MAP, map);
		apb_write(REG_BASE_NOTE, {57'd0, base});
		apb_write(REG_ON_VELOCITY, {57'd0, vel});
		apb_write(REG_LOCKOUT_MS, {56'd0, lockout});
		settings_used++;
	endtask

	task automatic add_scan(input logic [31:0] stamp, input logic [NUM_CHANNELS-1:0] levels);
		scan_word_t s;
		s.stamp = stamp;
		s.levels = levels;
		pending_scans.push_back(s);
	endtask

	task automatic drain_and_settle();
		while (pending_scans.size() != 0 || in_valid || expected_notes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic queue_random_scans(input int count);
		logic [NUM_CHANNELS-1:0] lv;
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				ms_clock = $urandom();
				lv = NUM_CHANNELS'($urandom());
			end else begin
				if (pick < 12) ms_clock = 32'hFFFF_FF00 | $urandom_range(0, 255);
				ms_clock = ms_clock + $urandom_range(0, 2 * cur_lockout + 2);
				if (pick < 18) begin
					lv = pick[0] ? '0 : '1;
				end else begin
					lv = key_shape;
					repeat ($urandom_range(1, 3)) lv[$urandom_range(0, NUM_CHANNELS - 1)] ^= 1'b1;
				end
			end
			key_shape = lv;
			add_scan(ms_clock, lv);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			now_ms <= '0;
			pin_levels <= '1;
		end else begin
			if (in_valid && !in_stall) begin
				predict_scan_notes(now_ms, pin_levels);
				scans_sent++;
				if ($urandom_range(0, 29) == 0) drain_pause = 1'b1;
			end
			if (drain_pause && expected_notes.size() == 0) drain_pause = 1'b0;
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_scans.size() > 0 && !drain_pause) begin
					next_scan = pending_scans.pop_front();
					in_valid <= 1'b1;
					now_ms <= next_scan.stamp;
					pin_levels <= next_scan.levels;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_COIN: out_stall <= 1'($urandom_range(0, 1));
				default: begin
					if (run_left == 0) begin
						run_left = $urandom_range(1, 25);
						run_level = ~run_level;
					end else begin
						run_left--;
					end
					out_stall <= run_level;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_notes.size() == 0) begin
				$error("note word with none expected: status %0d note %0d", status_byte,
					note_number);
				errors++;
			end else begin
				oldest_note = expected_notes.pop_front();
				check_field("status_byte", oldest_note.status, status_byte);
				check_field("note_number", {1'b0, oldest_note.note}, {1'b0, note_number});
				check_field("velocity", {1'b0, oldest_note.vel}, {1'b0, velocity});
				check_field("led_level", {7'd0, oldest_note.led}, {7'd0, led_level});
				check_field("last_of_scan", {7'd0, oldest_note.last}, {7'd0, last_of_scan});
				notes_checked++;
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		add_scan(32'd5, 13'h0000);
		add_scan(32'd9, 13'h1FFE);
		add_scan(32'd10, 13'h0000);
		add_scan(32'd15, 13'h1FFF);
		add_scan(32'd20, 13'h1FFF);
		add_scan(32'd30, 13'h0AAA);
		add_scan(32'd35, 13'h1555);
		add_scan(32'd40, 13'h1555);
		add_scan(32'd50, 13'h1FFF);
		drain_and_settle();

		program_settings({12'd0, {MAP_W{1'b1}}}, 7'd120, 7'd0, 8'd0);
		add_scan(32'd50, 13'h1FFF);
		add_scan(32'd51, 13'h0000);
		add_scan(32'd51, 13'h1FFF);
		add_scan(32'd52, 13'h1000);
		add_scan(32'd53, 13'h0001);
		drain_and_settle();

		program_settings(64'd0, 7'd0, 7'd127, 8'd10);
		add_scan(32'hFFFF_FFF8, 13'h0000);
		add_scan(32'h0000_0003, 13'h1FFF);
		add_scan(32'h0000_0005, 13'h0000);
		add_scan(32'h0000_000C, 13'h0000);
		add_scan(32'h0000_000D, 13'h0000);
		drain_and_settle();

		ms_clock = 32'd1000;
		key_shape = '0;
		program_settings({$urandom(), $urandom()}, 7'd0, 7'd1, 8'd255);
		queue_random_scans(35);
		drain_and_settle();
		program_settings({$urandom(), $urandom()}, 7'd112, 7'd127, 8'd0);
		queue_random_scans(35);
		drain_and_settle();
		program_settings(64'd0, 7'($urandom_range(0, 112)), 7'($urandom_range(1, 127)),
			8'($urandom_range(0, 255)));
		queue_random_scans(35);
		drain_and_settle();
		program_settings({$urandom(), $urandom()}, 7'd127, 7'd64, 8'd3);
		queue_random_scans(35);
		drain_and_settle();
		program_settings({$urandom(), $urandom()}, 7'($urandom_range(0, 112)),
			7'($urandom_range(1, 127)), 8'($urandom_range(0, 40)));
		queue_random_scans(35);
		drain_and_settle();
		program_settings({12'd0, NOTE_MAP_RST}, BASE_NOTE_RST, ON_VELOCITY_RST, LOCKOUT_MS_RST);
		queue_random_scans(35);
		drain_and_settle();

		$display("Ran %0d key scans under %0d register settings, %0d note words checked.",
			scans_sent, settings_used, notes_checked);
		if (errors == 0 && expected_notes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
